// ===== hw/rtl/uwc_pkg.sv =====
// shared types and constants for the utf-8 display width counter
package uwc_pkg;

    localparam int unsigned CP_BITS  = 21;
    localparam int unsigned OUT_BITS = 16;

    typedef logic [CP_BITS-1:0] codepoint_t;
    typedef logic [1:0]         cols_t;

    // one byte request as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } step_t;

    // result fields produced for a last request
    typedef struct packed {
        logic [OUT_BITS-1:0] display_width;
        logic [OUT_BITS-1:0] char_count;
        logic                truncated;
    } res_t;

endpackage

// ===== hw/rtl/utf8_display_width_counter.sv =====
// top level: utf-8 string display width and character counter
// a last request passes the input register, then its result is held in the result register
// throughput: one byte request per cycle while item_stall is low, set by the single state update stage
// a result waiting under result_stall blocks only a following last request
// reset (rst_n low, asynchronous) empties both registers and clears the counters
module utf8_display_width_counter
#(
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] display_width,
    output logic [15:0] char_count,
    output logic        truncated
);

    // input register
    logic           s1_valid_reg, s1_valid_next;
    uwc_pkg::step_t s1_item_reg;

    // result register
    logic           res_valid_reg, res_valid_next;
    uwc_pkg::res_t  res_reg;

    uwc_pkg::res_t  res_comb;
    logic           s1_go;
    logic           advance;
    logic           accept;

    // a last request may only move on when the result slot frees up
    assign s1_go      = !(s1_item_reg.last && res_valid_reg && result_stall);
    assign advance    = s1_valid_reg && s1_go;
    assign item_stall = s1_valid_reg && !s1_go;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.data_byte    <= data_byte;
            s1_item_reg.byte_present <= byte_present;
            s1_item_reg.last         <= last;
        end
    end

    // decode, classify and count in one pass
    uwc_core
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .res     (res_comb)
    );

    always_comb
    begin
        if (advance && s1_item_reg.last)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_item_reg.last)
        begin
            res_reg <= res_comb;
        end
    end

    assign result_valid  = res_valid_reg;
    assign display_width = res_reg.display_width;
    assign char_count    = res_reg.char_count;
    assign truncated     = res_reg.truncated;

endmodule

// ===== hw/rtl/uwc_width_class.sv =====
// terminal column class of one codepoint
module uwc_width_class
(
    input  uwc_pkg::codepoint_t cp,
    output uwc_pkg::cols_t      cols
);

    always_comb
    begin
        if (cp inside {[21'h000000:21'h00001F], [21'h00007F:21'h00009F]})
        begin
            cols = 2'd0;
        end
        else if (cp inside {[21'h001100:21'h00115F], [21'h002E80:21'h00303E],
                            [21'h003041:21'h0033FF], [21'h003400:21'h004DBF],
                            [21'h004E00:21'h009FFF], [21'h00A000:21'h00A4CF],
                            [21'h00AC00:21'h00D7A3], [21'h00F900:21'h00FAFF],
                            [21'h00FE30:21'h00FE4F], [21'h00FF00:21'h00FF60],
                            [21'h00FFE0:21'h00FFE6], [21'h01F300:21'h01F9FF],
                            [21'h020000:21'h02FFFD]})
        begin
            cols = 2'd2;
        end
        else
        begin
            cols = 2'd1;
        end
    end

endmodule

// ===== hw/rtl/uwc_core.sv =====
// utf-8 sequence state, saturating width and character counters
module uwc_core
#(
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  uwc_pkg::step_t item,
    output uwc_pkg::res_t  res
);

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [1:0]          rem_reg, rem_next;
    uwc_pkg::codepoint_t part_reg, part_next;
    logic [COUNT_BITS-1:0] width_reg, width_next;
    logic [COUNT_BITS-1:0] chars_reg, chars_next;

    logic                open;
    logic                is_lead;
    logic                add_width;
    uwc_pkg::codepoint_t folded;
    uwc_pkg::codepoint_t class_cp;
    uwc_pkg::cols_t      cols;
    logic [COUNT_BITS:0] width_sum;
    logic [COUNT_BITS:0] chars_sum;
    logic [COUNT_BITS-1:0] width_upd;
    logic [COUNT_BITS-1:0] chars_upd;
    logic [1:0]          rem_upd;
    uwc_pkg::codepoint_t part_upd;

    assign open    = (rem_reg != 2'd0);
    assign is_lead = ((item.data_byte & LEAD2_MASK) == LEAD2_CODE)
                  || ((item.data_byte & LEAD3_MASK) == LEAD3_CODE)
                  || ((item.data_byte & LEAD4_MASK) == LEAD4_CODE);
    assign folded  = {part_reg[uwc_pkg::CP_BITS-7:0], item.data_byte[5:0]};
    assign class_cp = open ? folded : {{(uwc_pkg::CP_BITS-8){1'b0}}, item.data_byte};

    uwc_width_class u_class
    (
        .cp   (class_cp),
        .cols (cols)
    );

    assign add_width = item.byte_present && (open ? (rem_reg == 2'd1) : !is_lead);

    assign width_sum = {1'b0, width_reg}
                     + {{(COUNT_BITS-1){1'b0}}, (add_width ? cols : 2'd0)};
    assign chars_sum = {1'b0, chars_reg}
                     + {{COUNT_BITS{1'b0}}, (item.byte_present && !open)};

    assign width_upd = width_sum[COUNT_BITS] ? COUNT_MAX : width_sum[COUNT_BITS-1:0];
    assign chars_upd = chars_sum[COUNT_BITS] ? COUNT_MAX : chars_sum[COUNT_BITS-1:0];

    // sequence tracking for this byte
    always_comb
    begin
        rem_upd  = rem_reg;
        part_upd = part_reg;
        if (item.byte_present)
        begin
            if (open)
            begin
                rem_upd  = rem_reg - 2'd1;
                part_upd = (rem_reg == 2'd1) ? '0 : folded;
            end
            else if ((item.data_byte & LEAD2_MASK) == LEAD2_CODE)
            begin
                rem_upd  = 2'd1;
                part_upd = {{(uwc_pkg::CP_BITS-8){1'b0}}, item.data_byte & 8'h1F};
            end
            else if ((item.data_byte & LEAD3_MASK) == LEAD3_CODE)
            begin
                rem_upd  = 2'd2;
                part_upd = {{(uwc_pkg::CP_BITS-8){1'b0}}, item.data_byte & 8'h0F};
            end
            else if ((item.data_byte & LEAD4_MASK) == LEAD4_CODE)
            begin
                rem_upd  = 2'd3;
                part_upd = {{(uwc_pkg::CP_BITS-8){1'b0}}, item.data_byte & 8'h07};
            end
        end
    end

    // output view of the counters, clamped to the field width
    generate
        if (COUNT_BITS > uwc_pkg::OUT_BITS)
        begin : g_wide
            assign res.display_width = (|width_upd[COUNT_BITS-1:uwc_pkg::OUT_BITS])
                ? {uwc_pkg::OUT_BITS{1'b1}} : width_upd[uwc_pkg::OUT_BITS-1:0];
            assign res.char_count = (|chars_upd[COUNT_BITS-1:uwc_pkg::OUT_BITS])
                ? {uwc_pkg::OUT_BITS{1'b1}} : chars_upd[uwc_pkg::OUT_BITS-1:0];
        end
        else if (COUNT_BITS == uwc_pkg::OUT_BITS)
        begin : g_equal
            assign res.display_width = width_upd;
            assign res.char_count    = chars_upd;
        end
        else
        begin : g_narrow
            assign res.display_width = {{(uwc_pkg::OUT_BITS-COUNT_BITS){1'b0}}, width_upd};
            assign res.char_count    = {{(uwc_pkg::OUT_BITS-COUNT_BITS){1'b0}}, chars_upd};
        end
    endgenerate

    assign res.truncated = (rem_upd != 2'd0);

    // end of string clears everything
    always_comb
    begin
        if (item.last)
        begin
            rem_next   = 2'd0;
            part_next  = '0;
            width_next = '0;
            chars_next = '0;
        end
        else
        begin
            rem_next   = rem_upd;
            part_next  = part_upd;
            width_next = width_upd;
            chars_next = chars_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= 2'd0;
            part_reg  <= '0;
            width_reg <= '0;
            chars_reg <= '0;
        end
        else if (advance)
        begin
            rem_reg   <= rem_next;
            part_reg  <= part_next;
            width_reg <= width_next;
            chars_reg <= chars_next;
        end
    end

endmodule

// ===== hw/rtl/uwc_checker.sv =====
// port level checks for the utf-8 display width counter, bound to the top level
module uwc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic [7:0]  data_byte,
    input logic        byte_present,
    input logic        last,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] display_width,
    input logic [15:0] char_count,
    input logic        truncated
);

    // no result during reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(display_width)
            && $stable(char_count) && $stable(truncated))
        else $error("stalled result changed");

    // input side only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("request stalled with no waiting result");

    // a cut off sequence means at least one character started
    a_trunc_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && truncated |-> char_count != 16'd0)
        else $error("truncated result with zero characters");

    // each character adds at most two columns
    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> {1'b0, display_width} <= {char_count, 1'b0})
        else $error("width exceeds twice the character count");

endmodule

bind utf8_display_width_counter uwc_checker u_uwc_checker (.*);

// ===== verif/tb_top.sv =====
// self-checking testbench for the utf-8 display width counter
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_BITS   = 16;
    localparam int unsigned COUNT_MAX    = (1 << COUNT_BITS) - 1;
    localparam int unsigned OUT_MAX      = 16'hFFFF;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned RANDOM_BYTES = 1500;
    localparam int unsigned LONG_BYTES   = 300;

    // lead and continuation patterns of utf-8
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD2      = 8'hC0;
    localparam logic [7:0] LEAD3      = 8'hE0;
    localparam logic [7:0] LEAD4      = 8'hF0;
    localparam logic [7:0] CONT       = 8'h80;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    logic        clk;
    logic        rst_n;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic [7:0]  data_byte    = 8'h00;
    logic        byte_present = 1'b0;
    logic        last         = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [15:0] display_width;
    logic [15:0] char_count;
    logic        truncated;

    utf8_display_width_counter #(
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .data_byte     (data_byte),
        .byte_present  (byte_present),
        .last          (last),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .display_width (display_width),
        .char_count    (char_count),
        .truncated     (truncated)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // predicted decoder state, mirrors what the block holds between bytes
    logic [1:0]          pend_bytes = '0;
    uwc_pkg::codepoint_t cp_build   = '0;
    int unsigned         col_sum    = 0;
    int unsigned         char_sum   = 0;

    // totals still owed by the block, oldest first
    uwc_pkg::res_t pending_totals[$];

    // bytes of the string being built by a test
    logic [7:0]  string_bytes[$];

    // boundaries of the zero- and double-width classes, probed at +/- 1
    int unsigned range_edges [0:28] = '{
        'h20, 'h7F, 'hA0, 'h1100, 'h115F, 'h2E80, 'h303E, 'h3041, 'h33FF,
        'h3400, 'h4DBF, 'h4E00, 'h9FFF, 'hA000, 'hA4CF, 'hAC00, 'hD7A3,
        'hF900, 'hFAFF, 'hFE30, 'hFE4F, 'hFF00, 'hFF60, 'hFFE0, 'hFFE6,
        'h1F300, 'h1F9FF, 'h20000, 'h2FFFD
    };

    bit          sender_idle  = 1'b1;
    bit          recv_idle    = 1'b1;
    int unsigned stall_left   = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned request_count = 0;
    int unsigned strings_sent = 0;
    int unsigned results_seen = 0;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic int unsigned bump(int unsigned total, int unsigned n);
        return (total + n > COUNT_MAX) ? COUNT_MAX : total + n;
    endfunction

    // terminal columns of one codepoint
    function automatic uwc_pkg::cols_t column_count(uwc_pkg::codepoint_t cp);
        if (cp < 'h20 || (cp >= 'h7F && cp < 'hA0))
            return 2'd0;
        if ((cp >= 'h1100  && cp <= 'h115F)  || (cp >= 'h2E80  && cp <= 'h303E) ||
            (cp >= 'h3041  && cp <= 'h33FF)  || (cp >= 'h3400  && cp <= 'h4DBF) ||
            (cp >= 'h4E00  && cp <= 'h9FFF)  || (cp >= 'hA000  && cp <= 'hA4CF) ||
            (cp >= 'hAC00  && cp <= 'hD7A3)  || (cp >= 'hF900  && cp <= 'hFAFF) ||
            (cp >= 'hFE30  && cp <= 'hFE4F)  || (cp >= 'hFF00  && cp <= 'hFF60) ||
            (cp >= 'hFFE0  && cp <= 'hFFE6)  || (cp >= 'h1F300 && cp <= 'h1F9FF) ||
            (cp >= 'h20000 && cp <= 'h2FFFD))
            return 2'd2;
        return 2'd1;
    endfunction

    // one byte into the decoder: leads open a sequence, anything else is taken
    // as a continuation while one is open
    function automatic void absorb_byte(logic [7:0] b);
        if (pend_bytes == 2'd0)
        begin
            char_sum = bump(char_sum, 1);
            if ((b & LEAD2_MASK) == LEAD2)
            begin
                cp_build   = uwc_pkg::codepoint_t'(b[4:0]);
                pend_bytes = 2'd1;
            end
            else if ((b & LEAD3_MASK) == LEAD3)
            begin
                cp_build   = uwc_pkg::codepoint_t'(b[3:0]);
                pend_bytes = 2'd2;
            end
            else if ((b & LEAD4_MASK) == LEAD4)
            begin
                cp_build   = uwc_pkg::codepoint_t'(b[2:0]);
                pend_bytes = 2'd3;
            end
            else
                col_sum = bump(col_sum, column_count(uwc_pkg::codepoint_t'(b)));
        end
        else
        begin
            cp_build   = {cp_build[uwc_pkg::CP_BITS-7:0], b[5:0]};
            pend_bytes = pend_bytes - 2'd1;
            if (pend_bytes == 2'd0)
            begin
                col_sum  = bump(col_sum, column_count(cp_build));
                cp_build = '0;
            end
        end
    endfunction

    // called for every accepted request
    function automatic void predict_totals(logic [7:0] b, logic present, logic is_last);
        uwc_pkg::res_t owed;
        if (present)
            absorb_byte(b);
        if (is_last)
        begin
            owed.display_width = (col_sum > OUT_MAX) ? 16'hFFFF : col_sum[15:0];
            owed.char_count    = (char_sum > OUT_MAX) ? 16'hFFFF : char_sum[15:0];
            owed.truncated     = (pend_bytes != 2'd0);
            pending_totals = {pending_totals, owed};
            pend_bytes = '0;
            cp_build   = '0;
            col_sum    = 0;
            char_sum   = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // string building
    // ---------------------------------------------------------------

    // append one byte to the string under construction
    function automatic void add_byte(logic [7:0] b);
        string_bytes = {string_bytes, b};
    endfunction

    // standard utf-8 form by value, 4-byte leads reach 0xF7 for 21-bit values
    function automatic void encode_char(int unsigned cp);
        if (cp < 'h80)
            add_byte(8'(cp));
        else if (cp < 'h800)
        begin
            add_byte(LEAD2 | 8'(cp >> 6));
            add_byte(CONT | (8'(cp) & CONT_BITS));
        end
        else if (cp < 'h10000)
        begin
            add_byte(LEAD3 | 8'(cp >> 12));
            add_byte(CONT | (8'(cp >> 6) & CONT_BITS));
            add_byte(CONT | (8'(cp) & CONT_BITS));
        end
        else
        begin
            add_byte(LEAD4 | (8'(cp >> 18) & 8'h07));
            add_byte(CONT | (8'(cp >> 12) & CONT_BITS));
            add_byte(CONT | (8'(cp >> 6) & CONT_BITS));
            add_byte(CONT | (8'(cp) & CONT_BITS));
        end
    endfunction

    function automatic int unsigned pick_codepoint();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: return $urandom_range(0, 'h7F);
            3:       return $urandom_range('h80, 'h7FF);
            4:       return $urandom_range('h800, 'hFFFF);
            5:       return $urandom_range('h10000, 'h1FFFFF);
            default: return range_edges[$urandom_range(0, 28)] + $urandom_range(0, 2) - 1;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // drive one request at the falling edge, hold it until accepted
    task automatic send_request(input logic [7:0] b, input logic present, input logic is_last);
        int unsigned gap;
        gap = sender_idle ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid   <= 1'b1;
        data_byte    <= b;
        byte_present <= present;
        last         <= is_last;
        do
            @(posedge clk);
        while (item_stall);
        predict_totals(b, present, is_last);
        if (present)
            request_count++;
    endtask

    // send the built string, ending on its final byte or with a bare end marker;
    // noop_pct sprinkles in requests that carry neither byte nor end
    task automatic send_string(input bit end_marker, input int unsigned noop_pct);
        int unsigned i;
        for (i = 0; i < string_bytes.size(); i++)
        begin
            if ($urandom_range(0, 99) < noop_pct)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(string_bytes[i], 1'b1,
                         !end_marker && (i == string_bytes.size() - 1));
        end
        if (end_marker || string_bytes.size() == 0)
            send_request(8'($urandom), 1'b0, 1'b1);
        string_bytes.delete();
        strings_sent++;
    endtask

    // sender goes quiet until every owed result has come back
    task automatic wait_for_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    // stall count is drawn after each accepted result and played out here
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
            result_stall <= 1'b0;
    end

    // compare each accepted result with the oldest owed one
    always @(posedge clk)
    begin
        uwc_pkg::res_t owed;
        if (rst_n && result_valid && !result_stall)
        begin
            stall_left = recv_idle ? $urandom_range(0, 15) : 0;
            if (pending_totals.size() == 0)
            begin
                $error("result with nothing owed: width %0d count %0d cut %0b",
                       display_width, char_count, truncated);
                error_count++;
            end
            else
            begin
                owed = pending_totals.pop_front();
                results_seen++;
                if (display_width !== owed.display_width)
                begin
                    $error("display_width: expected %0d, got %0d",
                           owed.display_width, display_width);
                    error_count++;
                end
                if (char_count !== owed.char_count)
                begin
                    $error("char_count: expected %0d, got %0d", owed.char_count, char_count);
                    error_count++;
                end
                if (truncated !== owed.truncated)
                begin
                    $error("truncated: expected %0b, got %0b", owed.truncated, truncated);
                    error_count++;
                end
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // nul, control range edges, stray continuation, invalid lead,
    // then a 2-byte char whose final byte carries the end
    task automatic test_single_byte_classes();
        string_bytes = '{8'h00, 8'h7E, 8'h7F, 8'h80, 8'hFF, 8'hC2, 8'hA0};
        send_string(1'b0, 0);
        string_bytes = '{8'h1F, 8'h20, 8'hC2, 8'h9F};
        send_string(1'b0, 0);
    endtask

    // unchecked continuation on an overlong lead, wide cjk, wide emoji,
    // and the largest value a 0xF7 lead can build
    task automatic test_multibyte_forms();
        string_bytes = '{8'hC0, 8'h41,
                         8'hE4, 8'hB8, 8'h80,
                         8'hF0, 8'h9F, 8'h8C, 8'h80,
                         8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_string(1'b0, 0);
    endtask

    // request with no byte and no end, two cut-off sequences, and an empty string
    task automatic test_cut_off_and_empty();
        send_request(8'hAA, 1'b0, 1'b0);
        string_bytes = '{8'hE4, 8'hB8};
        send_string(1'b1, 0);
        string_bytes = '{8'hF0, 8'h9F};
        send_string(1'b0, 0);
        send_string(1'b1, 0);
    endtask

    // one long string sent back to back with no result stalls
    task automatic test_long_string();
        int unsigned i;
        sender_idle = 1'b0;
        recv_idle   = 1'b0;
        for (i = 0; i < LONG_BYTES; i++)
            send_request(8'h41, 1'b1, 1'b0);
        string_bytes = '{8'hE4, 8'hB8, 8'h80};
        send_string(1'b0, 0);
        wait_for_results();
        sender_idle = 1'b1;
        recv_idle   = 1'b1;
    endtask

    // mostly well-formed strings with random content, some noise bytes,
    // cut-off endings and bare end markers; idling modes rotate
    task automatic test_random_strings();
        int unsigned nchars;
        int unsigned i;
        int unsigned ending;
        int unsigned chop;
        while (request_count < RANDOM_BYTES + LONG_BYTES)
        begin
            // both idle, sender only, receiver only, none
            sender_idle = ((strings_sent / 20) % 4) < 2;
            recv_idle   = ((strings_sent / 20) % 2) == 0;
            nchars = $urandom_range(0, 12);
            for (i = 0; i < nchars; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_byte(8'($urandom));
                else
                    encode_char(pick_codepoint());
            end
            ending = $urandom_range(0, 19);
            if (ending < 3)
            begin
                // cut the final multibyte char short
                encode_char($urandom_range('h80, 'h1FFFFF));
                chop = $urandom_range(1, (string_bytes[$] == 8'h00) ? 1 : 1);
                void'(string_bytes.pop_back());
                if ($urandom_range(0, 1) && string_bytes.size() > 1 && chop == 1)
                    void'(string_bytes.pop_back());
                send_string(1'($urandom_range(0, 1)), 4);
            end
            else
                send_string(ending < 5, 4);
            if (strings_sent % 30 == 0)
                wait_for_results();
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_byte_classes();
        test_multibyte_forms();
        test_cut_off_and_empty();
        wait_for_results();
        test_long_string();
        test_random_strings();

        // drain, then give the pipe room to show anything extra
        wait_for_results();
        repeat (10) @(posedge clk);
        if (pending_totals.size() != 0)
        begin
            $error("%0d results never arrived", pending_totals.size());
            error_count++;
        end

        $display("tb_top: %0d strings, %0d bytes, %0d results compared in %0d cycles",
                 strings_sent, request_count, results_seen, cycle_count);
        $display("tb_top: control, wide, malformed, cut-off and long strings, random stalls");
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
